// ----- hdl/jhc_pkg.sv -----
package jhc_pkg;

    // Default sizing of the count store.
    localparam int BIN_BITS_DEF   = 4;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed field widths.
    localparam int VALUE_W        = 4;
    localparam int MAX_BIN_BITS   = 8;
    localparam int MAX_COUNT_BITS = 64;
    localparam int BINS_W         = 5;
    localparam int NV_W           = 2;
    localparam int OUT_W          = 32;

    // Stream and configuration port widths.
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Action codes carried in the input tuser.
    localparam logic ACT_COUNT = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_VARS    = 2'd0,
        CFG_BINS_FIRST  = 2'd1,
        CFG_BINS_SECOND = 2'd2,
        CFG_BINS_THIRD  = 2'd3
    } cfg_idx_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [NV_W-1:0]   num_vars;
        logic [BINS_W-1:0] bins_first;
        logic [BINS_W-1:0] bins_second;
        logic [BINS_W-1:0] bins_third;
    } cfg_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic update;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic out_blocked;
    } dp_status_t;

endpackage

// ----- hdl/jhc_ctrl.sv -----
module jhc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  jhc_pkg::dp_status_t status,
    output jhc_pkg::ctrl_cmd_t  cmd
);
    import jhc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the store with zeros after reset.
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // A read waits here while the result register is still held.
                if (!(status.is_read && status.out_blocked))
                begin
                    cmd.update   = 1'b1;
                    cmd.load_out = status.is_read;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/jhc_datapath.sv -----
module jhc_datapath #(
    parameter int BIN_BITS   = jhc_pkg::BIN_BITS_DEF,
    parameter int COUNT_BITS = jhc_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  jhc_pkg::cfg_t                   cfg,
    input  logic [jhc_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [jhc_pkg::IN_USER_W-1:0]   s_tuser,
    input  jhc_pkg::ctrl_cmd_t              cmd,
    output jhc_pkg::dp_status_t             status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [jhc_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import jhc_pkg::*;

    localparam int ADDR_W = 3 * BIN_BITS;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CMP_W  = MAX_BIN_BITS + 1;

    logic [MAX_BIN_BITS-1:0] bin_mask;
    logic [MAX_BIN_BITS-1:0] val_first;
    logic [MAX_BIN_BITS-1:0] val_second;
    logic [MAX_BIN_BITS-1:0] val_third;
    logic                    use_second;
    logic                    use_third;
    logic                    ok_first;
    logic                    ok_second;
    logic                    ok_third;
    logic [BIN_BITS-1:0]     addr_second;
    logic [BIN_BITS-1:0]     addr_third;
    logic [ADDR_W-1:0]       addr_in;
    logic                    ok_in;

    logic [ADDR_W-1:0]       addr_reg;
    logic                    action_reg;
    logic                    ok_reg;
    logic [ADDR_W-1:0]       clear_addr_reg;
    logic [COUNT_BITS-1:0]   rd_data_reg;
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;

    logic [COUNT_BITS-1:0]   mem [DEPTH];
    logic                    mem_we;
    logic [ADDR_W-1:0]       wr_addr;
    logic [COUNT_BITS-1:0]   wr_data;
    logic                    saturated;
    logic [MAX_COUNT_BITS-1:0] rd_wide;

    // Bin values masked to BIN_BITS; tdata holds value fields in nibbles 0..2.
    always_comb
    begin
        bin_mask   = (MAX_BIN_BITS'(1) << BIN_BITS) - MAX_BIN_BITS'(1);
        val_first  = MAX_BIN_BITS'(s_tdata[VALUE_W-1:0]) & bin_mask;
        val_second = MAX_BIN_BITS'(s_tdata[2*VALUE_W-1:VALUE_W]) & bin_mask;
        val_third  = MAX_BIN_BITS'(s_tdata[3*VALUE_W-1:2*VALUE_W]) & bin_mask;
    end

    // A zero variable count acts as one.
    assign use_second = (cfg.num_vars >= NV_W'(2));
    assign use_third  = (cfg.num_vars == NV_W'(3));

    // Tuple address from the active values only.
    assign addr_second = use_second ? val_second[BIN_BITS-1:0] : '0;
    assign addr_third  = use_third ? val_third[BIN_BITS-1:0] : '0;
    assign addr_in     = {addr_third, addr_second, val_first[BIN_BITS-1:0]};

    // A sample counts only when every active value is present and in range.
    assign ok_first  = !s_tdata[3*VALUE_W]
                       && (CMP_W'(val_first) < CMP_W'(cfg.bins_first));
    assign ok_second = !s_tdata[3*VALUE_W+1]
                       && (CMP_W'(val_second) < CMP_W'(cfg.bins_second));
    assign ok_third  = !s_tdata[3*VALUE_W+2]
                       && (CMP_W'(val_third) < CMP_W'(cfg.bins_third));
    assign ok_in     = ok_first && (!use_second || ok_second) && (!use_third || ok_third);

    // Item registers, loaded when a beat is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg   <= addr_in;
            action_reg <= s_tuser[0];
            ok_reg     <= ok_in;
        end
    end

    // Clearing sweep address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
        end
    end

    // Write-back value: zero for sweep or read, else a saturating increment if counted.
    always_comb
    begin
        saturated = &rd_data_reg;
        mem_we    = cmd.clear || cmd.update;
        wr_addr   = cmd.clear ? clear_addr_reg : addr_reg;
        if (cmd.clear || (action_reg == ACT_READ))
        begin
            wr_data = '0;
        end
        else if (ok_reg && !saturated)
        begin
            wr_data = rd_data_reg + COUNT_BITS'(1);
        end
        else
        begin
            wr_data = rd_data_reg;
        end
    end

    // Count store with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // Result register; the low 32 bits of the count go out.
    assign rd_wide = MAX_COUNT_BITS'(rd_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_tdata_reg <= rd_wide[OUT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(m_tdata_reg);

    // Status back to the controller.
    assign status.clear_last  = &clear_addr_reg;
    assign status.is_read     = (action_reg == ACT_READ);
    assign status.out_blocked = m_tvalid_reg && !m_tready;

`ifndef SYNTH
    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(m_tvalid_reg && !m_tready))
        else $error("result register overwritten while held");

    // Only a read item produces a result.
    a_load_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (action_reg == ACT_READ) && cmd.update)
        else $error("result loaded for a count item");

    // No item is taken while the store is being cleared.
    a_no_capture_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !cmd.clear)
        else $error("item accepted during clearing sweep");

    // The sweep stops after the last address.
    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clear && (&clear_addr_reg)) |=> !cmd.clear)
        else $error("clearing sweep ran past the last address");
`endif

endmodule

// ----- hdl/joint_histogram_counter_top.sv -----
// Joint histogram of up to three binned variables. Each input beat is either a
// sample to count (tuser 0) or a read-and-clear of one tuple's counter (tuser 1);
// a read returns exactly one output beat, a count returns none. An item passes
// through capture, a registered read of the count store and write-back in that
// order; a read may wait in write-back
// while the previous result is still held on the output. After reset the block
// sweeps zeros through all 2^(3*BIN_BITS) counters, 4096 of them at the default
// BIN_BITS of 4, and accepts no item until that sweep is done; configuration
// writes are taken at any time but should only be issued while the block is idle.
module joint_histogram_counter_top #(
    parameter int BIN_BITS   = jhc_pkg::BIN_BITS_DEF,
    parameter int COUNT_BITS = jhc_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // value_first[3:0], value_second[7:4], value_third[11:8],
    // missing_first[12], missing_second[13], missing_third[14], zero pad[15]
    input  logic [jhc_pkg::IN_DATA_W-1:0]   s_tdata,
    // action[0]
    input  logic [jhc_pkg::IN_USER_W-1:0]   s_tuser,
    // Output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tuple_count[31:0]
    output logic [jhc_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [jhc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jhc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import jhc_pkg::*;

    cfg_t       cfg_reg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_vars    <= NV_W'(1);
            cfg_reg.bins_first  <= BINS_W'(16);
            cfg_reg.bins_second <= BINS_W'(16);
            cfg_reg.bins_third  <= BINS_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NUM_VARS:    cfg_reg.num_vars    <= cfg_data[NV_W-1:0];
                CFG_BINS_FIRST:  cfg_reg.bins_first  <= cfg_data[BINS_W-1:0];
                CFG_BINS_SECOND: cfg_reg.bins_second <= cfg_data[BINS_W-1:0];
                CFG_BINS_THIRD:  cfg_reg.bins_third  <= cfg_data[BINS_W-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Controller.
    jhc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath with the count store.
    jhc_datapath #(
        .BIN_BITS   (BIN_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- dv/tb_joint_histogram_counter_top.sv -----
module tb_joint_histogram_counter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jhc_pkg::*;

    localparam int ADDR_W         = 3 * BIN_BITS_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_COUNT    = 8;
    localparam int HALF_PHASE     = 115;

    // One input beat: an action and three binned values with missing flags.
    typedef struct {
        logic             action;
        logic [VALUE_W-1:0] v_first;
        logic [VALUE_W-1:0] v_second;
        logic [VALUE_W-1:0] v_third;
        logic             m_first;
        logic             m_second;
        logic             m_third;
    } hist_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the configuration and of the count store.
    logic [NV_W-1:0]   nv_reg = 2'd1;
    logic [BINS_W-1:0] bins_first_reg = 5'd16;
    logic [BINS_W-1:0] bins_second_reg = 5'd16;
    logic [BINS_W-1:0] bins_third_reg = 5'd16;
    logic [OUT_W-1:0]  hist_mem [1 << ADDR_W];

    hist_beat_t       beat_queue [$];
    logic [OUT_W-1:0] pending_counts [$];
    hist_beat_t       on_bus;
    logic [OUT_W-1:0] want_count;
    logic             idle_on = 1'b1;
    int               in_gap = 0;
    int               out_gap = 0;
    int               quiet_cycles = 0;
    int               fail_count = 0;

    joint_histogram_counter_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        foreach (hist_mem[i])
        begin
            hist_mem[i] = '0;
        end
    end

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // Apply one accepted beat to the shadow store; a read queues the count it returns.
    task automatic update_histogram(input hist_beat_t bt);
        int unsigned       nv;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        nv = (nv_reg == 2'd0) ? 1 : nv_reg;
        addr = '0;
        addr[3:0] = bt.v_first;
        if (nv >= 2)
        begin
            addr[7:4] = bt.v_second;
        end
        if (nv >= 3)
        begin
            addr[11:8] = bt.v_third;
        end
        if (bt.action == ACT_READ)
        begin
            pending_counts.push_back(hist_mem[addr]);
            hist_mem[addr] = '0;
        end
        else
        begin
            hit = !bt.m_first && ({1'b0, bt.v_first} < bins_first_reg);
            if (nv >= 2)
            begin
                hit = hit && !bt.m_second && ({1'b0, bt.v_second} < bins_second_reg);
            end
            if (nv >= 3)
            begin
                hit = hit && !bt.m_third && ({1'b0, bt.v_third} < bins_third_reg);
            end
            if (hit && hist_mem[addr] != '1)
            begin
                hist_mem[addr] = hist_mem[addr] + OUT_W'(1);
            end
        end
    endtask

    function automatic void push_beat(input logic act, input logic [3:0] a, input logic [3:0] b,
                                      input logic [3:0] c, input logic ma, input logic mb,
                                      input logic mc);
        hist_beat_t bt;
        bt.action = act;
        bt.v_first = a;
        bt.v_second = b;
        bt.v_third = c;
        bt.m_first = ma;
        bt.m_second = mb;
        bt.m_third = mc;
        beat_queue.push_back(bt);
    endfunction

    function automatic logic [VALUE_W-1:0] value_below(input logic [BINS_W-1:0] lim);
        if (lim == 0 || lim >= 16)
        begin
            return VALUE_W'($urandom_range(0, 15));
        end
        return VALUE_W'($urandom_range(0, lim - 1));
    endfunction

    // Mostly well-formed samples over a small set of tuples so that reads find counts.
    task automatic queue_random(input int n);
        hist_beat_t       bt;
        logic [VALUE_W-1:0] pool_a [8];
        logic [VALUE_W-1:0] pool_b [8];
        logic [VALUE_W-1:0] pool_c [8];
        int               pick;
        int               r;
        for (int k = 0; k < 8; k++)
        begin
            pool_a[k] = value_below(bins_first_reg);
            pool_b[k] = value_below(bins_second_reg);
            pool_c[k] = value_below(bins_third_reg);
        end
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            pick = $urandom_range(0, 7);
            if (r < 75 && r >= 55)
            begin
                bt.action = 1'($urandom_range(0, 1));
                bt.v_first = VALUE_W'($urandom);
                bt.v_second = VALUE_W'($urandom);
                bt.v_third = VALUE_W'($urandom);
                bt.m_first = 1'($urandom_range(0, 1));
                bt.m_second = 1'($urandom_range(0, 1));
                bt.m_third = 1'($urandom_range(0, 1));
            end
            else
            begin
                bt.action = (r < 55) ? ACT_COUNT : ACT_READ;
                bt.v_first = pool_a[pick];
                bt.v_second = pool_b[pick];
                bt.v_third = pool_c[pick];
                if (r < 55)
                begin
                    bt.m_first = ($urandom_range(0, 15) == 0);
                    bt.m_second = ($urandom_range(0, 15) == 0);
                    bt.m_third = ($urandom_range(0, 15) == 0);
                end
                else
                begin
                    bt.m_first = 1'($urandom_range(0, 1));
                    bt.m_second = 1'($urandom_range(0, 1));
                    bt.m_third = 1'($urandom_range(0, 1));
                end
            end
            beat_queue.push_back(bt);
        end
    endtask

    // Block until every queued beat is accepted and every read result has come back.
    task automatic wait_drained();
        while (beat_queue.size() != 0 || s_tvalid || pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_NUM_VARS:    nv_reg = data[NV_W-1:0];
            CFG_BINS_FIRST:  bins_first_reg = data;
            CFG_BINS_SECOND: bins_second_reg = data;
            CFG_BINS_THIRD:  bins_third_reg = data;
            default: ;
        endcase
    endtask

    // Drain, let the last write-back finish, then load all four registers.
    task automatic write_config(input logic [NV_W-1:0] nv, input logic [BINS_W-1:0] b1,
                                input logic [BINS_W-1:0] b2, input logic [BINS_W-1:0] b3);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_NUM_VARS, {3'($urandom_range(0, 7)), nv});
        write_reg(CFG_BINS_FIRST, b1);
        write_reg(CFG_BINS_SECOND, b2);
        write_reg(CFG_BINS_THIRD, b3);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Input driver: present queued beats, with random gaps while idling is on.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                update_histogram(on_bus);
            end
            if (!s_tvalid || s_tready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 9) == 0)
                begin
                    in_gap = $urandom_range(0, 11);
                    s_tvalid <= 1'b0;
                end
                else if (beat_queue.size() > 0)
                begin
                    on_bus = beat_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {1'b0, on_bus.m_third, on_bus.m_second, on_bus.m_first,
                                on_bus.v_third, on_bus.v_second, on_bus.v_first};
                    s_tuser <= on_bus.action;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each result beat and stall the receiver at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_counts.size() == 0)
                begin
                    flag_error($sformatf("unexpected result beat: tuple_count=0x%08h", m_tdata));
                end
                else
                begin
                    want_count = pending_counts.pop_front();
                    if (m_tdata !== want_count)
                    begin
                        flag_error($sformatf("tuple_count mismatch: expected 0x%08h, got 0x%08h",
                                             want_count, m_tdata));
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                out_gap = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either stream.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[joint_histogram_counter_top] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [NV_W-1:0]   nv;
        logic [BINS_W-1:0] b1;
        logic [BINS_W-1:0] b2;
        logic [BINS_W-1:0] b3;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: one variable, 16 bins; unused values and flags are ignored.
        push_beat(ACT_COUNT, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0);
        push_beat(ACT_COUNT, 4'd0, 4'd9, 4'd3, 1'b0, 1'b1, 1'b1);
        push_beat(ACT_COUNT, 4'd15, 4'd15, 4'd15, 1'b0, 1'b1, 1'b1);
        push_beat(ACT_COUNT, 4'd3, 4'd0, 4'd0, 1'b1, 1'b0, 1'b0);
        push_beat(ACT_READ, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0);
        push_beat(ACT_READ, 4'd15, 4'd0, 4'd0, 1'b1, 1'b1, 1'b1);
        push_beat(ACT_READ, 4'd3, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0);
        push_beat(ACT_READ, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, 1'b0);

        // A variable count of zero behaves as one variable.
        write_config(2'd0, 5'd16, 5'd16, 5'd16);
        push_beat(ACT_COUNT, 4'd7, 4'd9, 4'd9, 1'b0, 1'b0, 1'b0);
        push_beat(ACT_READ, 4'd7, 4'd5, 4'd5, 1'b0, 1'b0, 1'b0);

        // Three variables, bin counts above range, at one and at sixteen.
        write_config(2'd3, 5'd31, 5'd1, 5'd16);
        push_beat(ACT_COUNT, 4'd15, 4'd0, 4'd15, 1'b0, 1'b0, 1'b0);
        push_beat(ACT_COUNT, 4'd15, 4'd1, 4'd15, 1'b0, 1'b0, 1'b0);
        push_beat(ACT_COUNT, 4'd15, 4'd0, 4'd15, 1'b0, 1'b0, 1'b1);
        push_beat(ACT_COUNT, 4'd15, 4'd0, 4'd15, 1'b0, 1'b0, 1'b0);
        push_beat(ACT_READ, 4'd15, 4'd0, 4'd15, 1'b1, 1'b1, 1'b1);
        push_beat(ACT_READ, 4'd15, 4'd1, 4'd15, 1'b0, 1'b0, 1'b0);

        // Two variables with a zero bin count: nothing is counted.
        write_config(2'd2, 5'd16, 5'd0, 5'd16);
        push_beat(ACT_COUNT, 4'd1, 4'd0, 4'd3, 1'b0, 1'b0, 1'b0);
        push_beat(ACT_READ, 4'd1, 4'd0, 4'd9, 1'b0, 1'b0, 1'b0);

        // Random phases, each split by a full drain of the results.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0: begin nv = 2'd3; b1 = 5'd16; b2 = 5'd16; b3 = 5'd16; end
                1: begin nv = 2'd2; b1 = 5'd1;  b2 = 5'd16; b3 = 5'd31; end
                2: begin nv = 2'd1; b1 = 5'd31; b2 = 5'd0;  b3 = 5'd5;  end
                3: begin nv = 2'd3; b1 = 5'd2;  b2 = 5'd3;  b3 = 5'd31; end
                default:
                begin
                    nv = NV_W'($urandom_range(0, 3));
                    b1 = ($urandom_range(0, 3) == 0) ? BINS_W'($urandom_range(0, 31))
                                                     : BINS_W'($urandom_range(1, 16));
                    b2 = ($urandom_range(0, 3) == 0) ? BINS_W'($urandom_range(0, 31))
                                                     : BINS_W'($urandom_range(1, 16));
                    b3 = ($urandom_range(0, 3) == 0) ? BINS_W'($urandom_range(0, 31))
                                                     : BINS_W'($urandom_range(1, 16));
                end
            endcase
            write_config(nv, b1, b2, b3);
            idle_on = (ph == PHASE_COUNT - 1) ? 1'b0 : (ph % 3 != 2);
            queue_random(HALF_PHASE);
            wait_drained();
            queue_random(HALF_PHASE);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_counts.size() == 0)
        begin
            $display("[joint_histogram_counter_top] OK");
        end
        else
        begin
            $display("[joint_histogram_counter_top] ERROR");
        end
        $finish;
    end

endmodule
